### rtl/core/ppc_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and constants for the planar pose compose core
package ppc_pkg;

    // field widths
    localparam int POS_W   = 32;
    localparam int ANG_W   = 16;
    localparam int PHASE_W = 32;

    // cordic datapath
    localparam int STEPS = 24;
    localparam int XY_W  = 34;
    localparam int Z_W   = 34;
    localparam int CS_W  = 33;

    // rotation datapath: translation is split into a high part and a 16-bit low part
    localparam int NEG_W      = POS_W + 1;
    localparam int LO_W       = 16;
    localparam int HI_W       = NEG_W - LO_W;
    localparam int OPA_W      = (HI_W > LO_W + 1) ? HI_W : LO_W + 1;
    localparam int PROD_W     = OPA_W + CS_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int DOT_W      = SUM_W + LO_W + 1;
    localparam int FRAC_SHIFT = 30;
    localparam int RND_W      = DOT_W - FRAC_SHIFT;
    localparam int RES_W      = ((RND_W > POS_W) ? RND_W : POS_W) + 1;

    // kind codes
    localparam logic KIND_COMPOSE = 1'b0;
    localparam logic KIND_INVERT  = 1'b1;

    // cordic start vector (gain compensated) and quarter turn in phase units
    localparam logic signed [XY_W-1:0]    CORDIC_GAIN = XY_W'(652032874);
    localparam logic signed [PHASE_W-1:0] QUARTER     = PHASE_W'(1) <<< (PHASE_W - 2);

    // round half up before dropping the q30 fraction
    localparam logic signed [DOT_W-1:0] ROUND_HALF = DOT_W'(1) <<< (FRAC_SHIFT - 1);

    // saturation bounds
    localparam logic signed [RES_W-1:0] RES_MAX = (RES_W'(1) <<< (POS_W - 1)) - RES_W'(1);
    localparam logic signed [RES_W-1:0] RES_MIN = -(RES_W'(1) <<< (POS_W - 1));
    localparam logic signed [POS_W-1:0] OUT_MAX = {1'b0, {(POS_W - 1){1'b1}}};
    localparam logic signed [POS_W-1:0] OUT_MIN = {1'b1, {(POS_W - 1){1'b0}}};

    // arctangent of 2^-i in phase units, full turn = 2^32
    localparam logic [31:0] ATAN_TABLE [STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic                    kind;
        logic signed [POS_W-1:0] first_x;
        logic signed [POS_W-1:0] first_y;
        logic signed [ANG_W-1:0] first_heading;
        logic signed [POS_W-1:0] second_x;
        logic signed [POS_W-1:0] second_y;
        logic signed [ANG_W-1:0] second_heading;
    } pose_t;

    typedef struct packed {
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
        logic signed [ANG_W-1:0] out_heading;
        logic                    saturated;
    } result_t;

    // cordic vector and residual phase
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } rot_t;

    // operands that ride along the cordic chain
    typedef struct packed {
        logic signed [NEG_W-1:0] px;
        logic signed [NEG_W-1:0] py;
        logic signed [POS_W-1:0] tx;
        logic signed [POS_W-1:0] ty;
        logic [ANG_W-1:0]        head;
        logic                    flip;
    } carry_t;

endpackage

### rtl/core/ppc_prep.sv
`timescale 1ns / 1ps
// input stage: operand setup, heading sum (or negation for invert) and phase range reduction
module ppc_prep
    import ppc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    input  pose_t  up_pose,
    output logic   up_ready,
    output logic   dn_valid,
    output rot_t   dn_rot,
    output carry_t dn_carry,
    input  logic   dn_ready
);

    logic                      valid_reg;
    logic signed [Z_W-1:0]     z_reg;
    logic signed [Z_W-1:0]     z_next;
    carry_t                    carry_reg;
    carry_t                    carry_next;

    logic [ANG_W-1:0]          fh;
    logic [ANG_W-1:0]          sh;
    logic [ANG_W-1:0]          head_src;
    logic [PHASE_W-1:0]        phase;
    logic [PHASE_W-1:0]        phase_red;
    logic signed [PHASE_W-1:0] z_raw;
    logic signed [NEG_W-1:0]   fx_ext;
    logic signed [NEG_W-1:0]   fy_ext;
    logic                      invert;

    // stage advances when empty or when downstream takes its transaction
    assign up_ready = !valid_reg || dn_ready;

    // operand selection and range reduction into [-pi/2, pi/2]
    always_comb
    begin
        invert   = (up_pose.kind == KIND_INVERT);
        fh       = up_pose.first_heading;
        sh       = up_pose.second_heading;
        head_src = invert ? (ANG_W'(0) - fh) : fh;
        phase    = {head_src, {(PHASE_W - ANG_W){1'b0}}};
        z_raw    = $signed(phase);
        fx_ext   = NEG_W'(up_pose.first_x);
        fy_ext   = NEG_W'(up_pose.first_y);

        carry_next.flip = (z_raw > QUARTER) || (z_raw < -QUARTER);
        phase_red = carry_next.flip ? {~phase[PHASE_W-1], phase[PHASE_W-2:0]} : phase;
        z_next    = Z_W'($signed(phase_red));

        if (invert)
        begin
            carry_next.px   = -fx_ext;
            carry_next.py   = -fy_ext;
            carry_next.tx   = '0;
            carry_next.ty   = '0;
            carry_next.head = head_src;
        end
        else
        begin
            carry_next.px   = NEG_W'(up_pose.second_x);
            carry_next.py   = NEG_W'(up_pose.second_y);
            carry_next.tx   = up_pose.first_x;
            carry_next.ty   = up_pose.first_y;
            carry_next.head = fh + sh;
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            z_reg     <= z_next;
            carry_reg <= carry_next;
        end
    end

    // start vector is constant, residual phase comes from the register
    assign dn_valid = valid_reg;
    assign dn_rot   = '{x: CORDIC_GAIN, y: '0, z: z_reg};
    assign dn_carry = carry_reg;

endmodule

### rtl/core/ppc_cordic_cell.sv
`timescale 1ns / 1ps
// one cordic rotation step with its pipeline register
module ppc_cordic_cell
    import ppc_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    input  rot_t   up_rot,
    input  carry_t up_carry,
    output logic   up_ready,
    output logic   dn_valid,
    output rot_t   dn_rot,
    output carry_t dn_carry,
    input  logic   dn_ready
);

    logic                   valid_reg;
    rot_t                   rot_reg;
    rot_t                   rot_next;
    carry_t                 carry_reg;

    logic signed [XY_W-1:0] x_in;
    logic signed [XY_W-1:0] y_in;
    logic signed [Z_W-1:0]  z_in;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  ang;

    assign up_ready = !valid_reg || dn_ready;

    // turn toward zero residual, zero counts as positive
    always_comb
    begin
        x_in = up_rot.x;
        y_in = up_rot.y;
        z_in = up_rot.z;
        dx   = y_in >>> STEP;
        dy   = x_in >>> STEP;
        ang  = $signed(Z_W'(ATAN_TABLE[STEP]));
        if (!z_in[Z_W-1])
        begin
            rot_next.x = x_in - dx;
            rot_next.y = y_in + dy;
            rot_next.z = z_in - ang;
        end
        else
        begin
            rot_next.x = x_in + dx;
            rot_next.y = y_in - dy;
            rot_next.z = z_in + ang;
        end
    end

    // cell valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    // cell payload
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            rot_reg   <= rot_next;
            carry_reg <= up_carry;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rot   = rot_reg;
    assign dn_carry = carry_reg;

endmodule

### rtl/core/ppc_rotate.sv
`timescale 1ns / 1ps
// translation rotation by cos/sin, rounding, offset add and saturation
module ppc_rotate
    import ppc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    input  logic signed [XY_W-1:0] up_x,
    input  logic signed [XY_W-1:0] up_y,
    input  carry_t                 up_carry,
    output logic                   up_ready,
    output logic                   dn_valid,
    output result_t                dn_result,
    input  logic                   dn_ready
);

    // stage valids and ready chain
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic s4_ready;

    // stage 1: partial products
    logic signed [CS_W-1:0]   c_w;
    logic signed [CS_W-1:0]   s_w;
    logic signed [CS_W-1:0]   ns_w;
    logic signed [OPA_W-1:0]  ah;
    logic signed [OPA_W-1:0]  al;
    logic signed [OPA_W-1:0]  bh;
    logic signed [OPA_W-1:0]  bl;
    logic signed [PROD_W-1:0] s1_xah_reg, s1_xah_next;
    logic signed [PROD_W-1:0] s1_xal_reg, s1_xal_next;
    logic signed [PROD_W-1:0] s1_xbh_reg, s1_xbh_next;
    logic signed [PROD_W-1:0] s1_xbl_reg, s1_xbl_next;
    logic signed [PROD_W-1:0] s1_yah_reg, s1_yah_next;
    logic signed [PROD_W-1:0] s1_yal_reg, s1_yal_next;
    logic signed [PROD_W-1:0] s1_ybh_reg, s1_ybh_next;
    logic signed [PROD_W-1:0] s1_ybl_reg, s1_ybl_next;
    logic signed [POS_W-1:0]  s1_tx_reg;
    logic signed [POS_W-1:0]  s1_ty_reg;
    logic [ANG_W-1:0]         s1_head_reg;

    // stage 2: high and low sums
    logic signed [SUM_W-1:0]  s2_xhi_reg;
    logic signed [SUM_W-1:0]  s2_xlo_reg;
    logic signed [SUM_W-1:0]  s2_yhi_reg;
    logic signed [SUM_W-1:0]  s2_ylo_reg;
    logic signed [POS_W-1:0]  s2_tx_reg;
    logic signed [POS_W-1:0]  s2_ty_reg;
    logic [ANG_W-1:0]         s2_head_reg;

    // stage 3: rounded rotation
    logic signed [DOT_W-1:0]  x_dot;
    logic signed [DOT_W-1:0]  y_dot;
    logic signed [RND_W-1:0]  s3_xr_reg, s3_xr_next;
    logic signed [RND_W-1:0]  s3_yr_reg, s3_yr_next;
    logic signed [POS_W-1:0]  s3_tx_reg;
    logic signed [POS_W-1:0]  s3_ty_reg;
    logic [ANG_W-1:0]         s3_head_reg;

    // stage 4: output register
    logic signed [RES_W-1:0]  x_sum;
    logic signed [RES_W-1:0]  y_sum;
    logic                     x_hi;
    logic                     x_lo;
    logic                     y_hi;
    logic                     y_lo;
    result_t                  s4_result_reg;
    result_t                  s4_result_next;

    assign s4_ready = !s4_valid_reg || dn_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign up_ready = s1_ready;

    // cos/sin with quadrant flip, translation split into high and low parts
    always_comb
    begin
        c_w  = CS_W'(up_carry.flip ? -up_x : up_x);
        s_w  = CS_W'(up_carry.flip ? -up_y : up_y);
        ns_w = -s_w;
        ah   = OPA_W'(up_carry.px >>> LO_W);
        al   = OPA_W'($signed({1'b0, up_carry.px[LO_W-1:0]}));
        bh   = OPA_W'(up_carry.py >>> LO_W);
        bl   = OPA_W'($signed({1'b0, up_carry.py[LO_W-1:0]}));

        s1_xah_next = PROD_W'(ah) * PROD_W'(c_w);
        s1_xal_next = PROD_W'(al) * PROD_W'(c_w);
        s1_xbh_next = PROD_W'(bh) * PROD_W'(ns_w);
        s1_xbl_next = PROD_W'(bl) * PROD_W'(ns_w);
        s1_yah_next = PROD_W'(ah) * PROD_W'(s_w);
        s1_yal_next = PROD_W'(al) * PROD_W'(s_w);
        s1_ybh_next = PROD_W'(bh) * PROD_W'(c_w);
        s1_ybl_next = PROD_W'(bl) * PROD_W'(c_w);
    end

    // recombine, round half up and drop the q30 fraction
    always_comb
    begin
        x_dot = (DOT_W'(s2_xhi_reg) <<< LO_W) + DOT_W'(s2_xlo_reg) + ROUND_HALF;
        y_dot = (DOT_W'(s2_yhi_reg) <<< LO_W) + DOT_W'(s2_ylo_reg) + ROUND_HALF;
        s3_xr_next = RND_W'(x_dot >>> FRAC_SHIFT);
        s3_yr_next = RND_W'(y_dot >>> FRAC_SHIFT);
    end

    // offset add and saturation
    always_comb
    begin
        x_sum = RES_W'(s3_xr_reg) + RES_W'(s3_tx_reg);
        y_sum = RES_W'(s3_yr_reg) + RES_W'(s3_ty_reg);
        x_hi  = x_sum > RES_MAX;
        x_lo  = x_sum < RES_MIN;
        y_hi  = y_sum > RES_MAX;
        y_lo  = y_sum < RES_MIN;
        s4_result_next.out_x       = x_hi ? OUT_MAX : (x_lo ? OUT_MIN : POS_W'(x_sum));
        s4_result_next.out_y       = y_hi ? OUT_MAX : (y_lo ? OUT_MIN : POS_W'(y_sum));
        s4_result_next.out_heading = s3_head_reg;
        s4_result_next.saturated   = x_hi || x_lo || y_hi || y_lo;
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= up_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (up_valid && s1_ready)
        begin
            s1_xah_reg  <= s1_xah_next;
            s1_xal_reg  <= s1_xal_next;
            s1_xbh_reg  <= s1_xbh_next;
            s1_xbl_reg  <= s1_xbl_next;
            s1_yah_reg  <= s1_yah_next;
            s1_yal_reg  <= s1_yal_next;
            s1_ybh_reg  <= s1_ybh_next;
            s1_ybl_reg  <= s1_ybl_next;
            s1_tx_reg   <= up_carry.tx;
            s1_ty_reg   <= up_carry.ty;
            s1_head_reg <= up_carry.head;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_xhi_reg  <= SUM_W'(s1_xah_reg) + SUM_W'(s1_xbh_reg);
            s2_xlo_reg  <= SUM_W'(s1_xal_reg) + SUM_W'(s1_xbl_reg);
            s2_yhi_reg  <= SUM_W'(s1_yah_reg) + SUM_W'(s1_ybh_reg);
            s2_ylo_reg  <= SUM_W'(s1_yal_reg) + SUM_W'(s1_ybl_reg);
            s2_tx_reg   <= s1_tx_reg;
            s2_ty_reg   <= s1_ty_reg;
            s2_head_reg <= s1_head_reg;
        end
        if (s2_valid_reg && s3_ready)
        begin
            s3_xr_reg   <= s3_xr_next;
            s3_yr_reg   <= s3_yr_next;
            s3_tx_reg   <= s2_tx_reg;
            s3_ty_reg   <= s2_ty_reg;
            s3_head_reg <= s2_head_reg;
        end
        if (s3_valid_reg && s4_ready)
            s4_result_reg <= s4_result_next;
    end

    assign dn_valid  = s4_valid_reg;
    assign dn_result = s4_result_reg;

endmodule

### rtl/core/planar_pose_compose_core.sv
`timescale 1ns / 1ps
// planar pose compose/invert core: prep stage, cordic cell chain, rotation stages
//
//  channel | signals                          | direction | transaction
//  pose    | pose_valid, pose_stall, pose     | in        | kind, first pose, second pose
//  result  | result_valid, result_stall, result | out     | position, heading, saturation
//
// one transaction per cycle sustained while result_stall is low; one input stage,
// 24 cordic cells and four rotation/round/saturate stages.
// reset is asynchronous and only clears the stage valid bits.
// every stage advances whenever it is empty or its successor advances, so
// bubbles close up under result_stall and pose_stall rises only once the
// whole chain is full.
module planar_pose_compose_core
    import ppc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pose_valid,
    output logic    pose_stall,
    input  pose_t   pose,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic   chain_valid [STEPS+1];
    logic   chain_ready [STEPS+1];
    rot_t   chain_rot   [STEPS+1];
    carry_t chain_carry [STEPS+1];
    logic   prep_ready;

    assign pose_stall = !prep_ready;

    // operand setup and range reduction
    ppc_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pose_valid),
        .up_pose  (pose),
        .up_ready (prep_ready),
        .dn_valid (chain_valid[0]),
        .dn_rot   (chain_rot[0]),
        .dn_carry (chain_carry[0]),
        .dn_ready (chain_ready[0])
    );

    // cordic cell chain, one rotation step per cell
    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        ppc_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_rot   (chain_rot[i]),
            .up_carry (chain_carry[i]),
            .up_ready (chain_ready[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_rot   (chain_rot[i+1]),
            .dn_carry (chain_carry[i+1]),
            .dn_ready (chain_ready[i+1])
        );
    end

    // rotation, rounding, offset and saturation
    ppc_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (chain_valid[STEPS]),
        .up_x      (chain_rot[STEPS].x),
        .up_y      (chain_rot[STEPS].y),
        .up_carry  (chain_carry[STEPS]),
        .up_ready  (chain_ready[STEPS]),
        .dn_valid  (result_valid),
        .dn_result (result),
        .dn_ready  (!result_stall)
    );

endmodule

### rtl/core/ppc_checker.sv
`timescale 1ns / 1ps
// port-level checker for the pose compose core and its bind
module ppc_checker
    import ppc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    pose_valid,
    input logic    pose_stall,
    input pose_t   pose,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // no result is shown in the cycle after reset is seen
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !result_valid)
        else $error("result_valid high during reset");

    // an empty output stage means the whole chain can move, so input is never held off
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !pose_stall)
        else $error("pose_stall high with empty output");

    // a saturated result carries a clipped position
    a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.saturated) |->
            (result.out_x == OUT_MAX || result.out_x == OUT_MIN ||
             result.out_y == OUT_MAX || result.out_y == OUT_MIN))
        else $error("saturated flag without clipped position");

    // a stalled result transaction is not withdrawn
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("result_valid dropped while stalled");

endmodule

bind planar_pose_compose_core ppc_checker u_checker (.*);
